>>> hw/rtl/tbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbf_pkg
// Shared codes and types for the transmit byte FIFO with statistics.
// ----------------------------------------------------------------------------
package tbf_pkg;

    // command codes carried on the slave tuser
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;

    localparam int unsigned CMD_W     = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_W     = 9;
    localparam int unsigned OVF_W     = 32;
    localparam int unsigned OUT_BITS  = BYTE_W + 1 + 1 + CNT_W + CNT_W + OVF_W + 1;
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W = OUT_TDATA_W - OUT_BITS;

    // controller to datapath
    typedef struct packed {
        logic capture;  // take the input beat, start the store read
        logic commit;   // update state and load the result register
    } t_ctl;

endpackage

>>> hw/rtl/tbf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/tbf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbf_ctrl
// Sequencer: takes a beat, waits for the store read, commits once the
// result register is free.
// ----------------------------------------------------------------------------
module tbf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output tbf_pkg::t_ctl o_ctl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_vld, n_out_vld;
    logic capture, commit;

    assign o_s_tready = (r_state == ST_IDLE);
    assign capture    = i_s_tvalid && o_s_tready;
    // result register frees up in the same cycle it is taken
    assign commit     = (r_state == ST_EXEC) && (!r_out_vld || i_m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (capture) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (commit) begin
            n_out_vld = 1'b1;
        end else if (i_m_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_m_tvalid    = r_out_vld;
    assign o_ctl.capture = capture;
    assign o_ctl.commit  = commit;

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_vld)
        else $error("result not presented after commit");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({capture, commit}))
        else $error("capture and commit in one cycle");

    a_exec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) && !commit |=> (r_state == ST_EXEC) && !o_s_tready)
        else $error("stalled item lost");

endmodule

>>> hw/rtl/tbf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbf_dpath
// Ring indices, statistics counters, byte store and result register.
// ----------------------------------------------------------------------------
module tbf_dpath #(
    parameter int unsigned DEPTH = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tbf_pkg::t_ctl                      i_ctl,
    input  logic [tbf_pkg::CMD_W-1:0]          i_cmd,
    input  logic [tbf_pkg::BYTE_W-1:0]         i_data,
    output logic [tbf_pkg::OUT_TDATA_W-1:0]    o_result
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [tbf_pkg::CMD_W-1:0]  r_cmd;
    logic [tbf_pkg::BYTE_W-1:0] r_data;
    logic [AW-1:0]              r_wr, n_wr, wr_nxt;
    logic [AW-1:0]              r_rd, n_rd, rd_nxt;
    logic [CW-1:0]              r_peak, n_peak, fill;
    logic [tbf_pkg::OVF_W-1:0]  r_ovf, n_ovf;
    logic [tbf_pkg::BYTE_W-1:0] ram_rdata;
    logic                       is_push, is_pop, full, empty, push_ok, pop_ok;
    logic [tbf_pkg::BYTE_W-1:0] r_o_byte;
    logic                       r_o_vld, r_o_acc, r_o_trq;
    logic [tbf_pkg::CNT_W-1:0]  r_o_pend, r_o_hw;
    logic [tbf_pkg::OVF_W-1:0]  r_o_ovf;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd  <= i_cmd;
            r_data <= i_data;
        end
    end

    assign wr_nxt  = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign rd_nxt  = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign full    = (wr_nxt == r_rd);
    assign empty   = (r_rd == r_wr);
    assign is_push = (r_cmd == tbf_pkg::CMD_PUSH);
    assign is_pop  = (r_cmd == tbf_pkg::CMD_POP);
    assign push_ok = is_push && !full;
    assign pop_ok  = is_pop && !empty;

    assign n_wr = push_ok ? wr_nxt : r_wr;
    assign n_rd = pop_ok ? rd_nxt : r_rd;

    // occupancy after this item
    assign fill = (n_wr >= n_rd) ? CW'(n_wr) - CW'(n_rd)
                                 : CW'(DEPTH) - CW'(n_rd) + CW'(n_wr);

    assign n_peak = (push_ok && (fill > r_peak)) ? fill : r_peak;
    assign n_ovf  = (is_push && full) ? r_ovf + 1'b1 : r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_peak <= '0;
            r_ovf  <= '0;
        end else if (i_ctl.commit) begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_peak <= n_peak;
            r_ovf  <= n_ovf;
        end
    end

    // read issued at capture so the byte is ready by commit
    tbf_ram #(
        .WIDTH (tbf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_ctl.commit && push_ok),
        .i_waddr (r_wr),
        .i_wdata (r_data),
        .i_re    (i_ctl.capture),
        .i_raddr (r_rd),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_o_byte <= pop_ok ? ram_rdata : '0;
            r_o_vld  <= pop_ok;
            r_o_acc  <= push_ok;
            r_o_pend <= tbf_pkg::CNT_W'(fill);
            r_o_hw   <= tbf_pkg::CNT_W'(n_peak);
            r_o_ovf  <= n_ovf;
            r_o_trq  <= (fill != '0);
        end
    end

    assign o_result = {{tbf_pkg::OUT_PAD_W{1'b0}}, r_o_trq, r_o_ovf, r_o_hw, r_o_pend,
                       r_o_acc, r_o_vld, r_o_byte};

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_wr) < DEPTH) && (32'(r_rd) < DEPTH))
        else $error("ring index out of range");

    a_ovf_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.commit |=> $stable(r_ovf) && $stable(r_wr) && $stable(r_rd))
        else $error("state moved without commit");

    a_peak_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |=> r_peak >= $past(r_peak))
        else $error("high-water mark fell");

endmodule

>>> hw/rtl/tx_byte_fifo_with_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx_byte_fifo_with_stats
// Transmit byte ring buffer with fill, high-water and overflow statistics.
// An accepted input beat is captured, then waits in the execute state for the
// registered read of the byte store, which is started at accept and
// consumed at commit; a new beat is accepted only once the last one commits.
// A stalled result holds the next item in the execute state until taken.
// Reset: synchronous, active low; clears indices, counters and handshake.
// The byte store is not cleared; only written entries are ever returned.
// ----------------------------------------------------------------------------
module tx_byte_fifo_with_stats #(
    parameter int unsigned DEPTH = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic [1:0]                      s_axis_tuser,  // [1:0] command
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] out_byte, [8] out_valid, [9] push_accepted, [18:10] pending_count,
    // [27:19] high_water, [59:28] overflow_count, [60] transmit_request
    output logic [tbf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    tbf_pkg::t_ctl ctl;

    tbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_ctl      (ctl)
    );

    tbf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_cmd    (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_result (m_axis_tdata)
    );

endmodule
